// ===== hdl/ssi_pkg.sv =====
// Shared widths, types and payload structs for the segment intersection core.
`default_nettype none

package ssi_pkg;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 8;
    localparam int OUT_W     = 24;

    // Derived datapath widths
    localparam int D_W   = COORD_W + 1;
    localparam int P_W   = 2 * D_W;
    localparam int DET_W = P_W + 1;
    localparam int MAG_W = COORD_W + FRAC_BITS;
    localparam int Q_W   = MAG_W;
    localparam int N_W   = DET_W + Q_W;
    localparam int TL_W  = DET_W / 2;
    localparam int TH_W  = DET_W - TL_W;
    localparam int V_W   = (MAG_W + 2 > OUT_W) ? MAG_W + 2 : OUT_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [MAG_W-1:0]   t_base;
    typedef logic        [DET_W-1:0]   t_det;
    typedef logic        [N_W-1:0]     t_num;

    // Endpoints of both segments
    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
        t_coord x3;
        t_coord y3;
        t_coord x4;
        t_coord y4;
    } t_pts;

    // Data that travels alongside the divider
    typedef struct packed {
        logic  hit;
        logic  neg_x;
        logic  neg_y;
        t_base base_x;
        t_base base_y;
        t_det  den;
    } t_side;

endpackage

`default_nettype wire

// ===== hdl/ssi_if.sv =====
// Request and result channel interfaces of the segment intersection core.
`default_nettype none

interface ssi_in_if;
    import ssi_pkg::*;
    logic   valid;
    logic   ready;
    t_coord first_start_x;
    t_coord first_start_y;
    t_coord first_end_x;
    t_coord first_end_y;
    t_coord second_start_x;
    t_coord second_start_y;
    t_coord second_end_x;
    t_coord second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

interface ssi_out_if;
    import ssi_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

// ===== hdl/ssi_front.sv =====
// Front pipeline: differences, cross products, sign normalization, hit test, numerators.
`default_nettype none

module ssi_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire ssi_pkg::t_pts  i_pts,
    output logic                o_vld,
    output ssi_pkg::t_num       o_num_x,
    output ssi_pkg::t_num       o_num_y,
    output ssi_pkg::t_side      o_side
);
    import ssi_pkg::*;

    typedef logic signed [D_W-1:0]   t_diff;
    typedef logic signed [P_W-1:0]   t_prod;
    typedef logic signed [DET_W-1:0] t_sdet;
    typedef logic        [MAG_W-1:0] t_mag;

    logic [6:0] r_vld;

    // Stage 1
    t_diff  r1_dx12, r1_dy12, r1_dx34, r1_dy34, r1_dx13, r1_dy13;
    t_coord r1_x1, r1_y1;
    // Stage 2
    t_prod  r2_a, r2_b, r2_c, r2_d, r2_e, r2_f;
    t_mag   r2_mag_x, r2_mag_y;
    logic   r2_neg_x, r2_neg_y;
    t_base  r2_base_x, r2_base_y;
    // Stage 3
    t_sdet  r3_den, r3_tn, r3_un;
    t_mag   r3_mag_x, r3_mag_y;
    logic   r3_neg_x, r3_neg_y;
    t_base  r3_base_x, r3_base_y;
    // Stage 4
    t_sdet  r4_den, r4_tn, r4_un;
    t_mag   r4_mag_x, r4_mag_y;
    logic   r4_neg_x, r4_neg_y;
    t_base  r4_base_x, r4_base_y;
    // Stage 5
    t_det   r5_den, r5_tn;
    logic   r5_hit;
    t_mag   r5_mag_x, r5_mag_y;
    logic   r5_neg_x, r5_neg_y;
    t_base  r5_base_x, r5_base_y;
    // Stage 6
    logic [MAG_W+TL_W-1:0] r6_px_lo, r6_py_lo;
    logic [MAG_W+TH_W-1:0] r6_px_hi, r6_py_hi;
    t_side  r6_side;
    // Stage 7
    t_num   r7_num_x, r7_num_y;
    t_side  r7_side;

    t_diff n1_dx12, n1_dy12, n1_dx34, n1_dy34, n1_dx13, n1_dy13;
    t_diff n2_abs_x, n2_abs_y;
    logic  n5_hit;

    // Differences of the endpoints
    always_comb begin
        n1_dx12 = t_diff'(i_pts.x1) - t_diff'(i_pts.x2);
        n1_dy12 = t_diff'(i_pts.y1) - t_diff'(i_pts.y2);
        n1_dx34 = t_diff'(i_pts.x3) - t_diff'(i_pts.x4);
        n1_dy34 = t_diff'(i_pts.y3) - t_diff'(i_pts.y4);
        n1_dx13 = t_diff'(i_pts.x1) - t_diff'(i_pts.x3);
        n1_dy13 = t_diff'(i_pts.y1) - t_diff'(i_pts.y3);
    end

    // Magnitude of the first segment's direction
    always_comb begin
        n2_abs_x = r1_dx12[D_W-1] ? -r1_dx12 : r1_dx12;
        n2_abs_y = r1_dy12[D_W-1] ? -r1_dy12 : r1_dy12;
    end

    // Both line parameters inside the closed unit range
    always_comb begin
        n5_hit = (r4_den != '0) && !r4_tn[DET_W-1] && !r4_un[DET_W-1]
            && (r4_tn <= r4_den) && (r4_un <= r4_den);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx12 <= n1_dx12;
            r1_dy12 <= n1_dy12;
            r1_dx34 <= n1_dx34;
            r1_dy34 <= n1_dy34;
            r1_dx13 <= n1_dx13;
            r1_dy13 <= n1_dy13;
            r1_x1   <= i_pts.x1;
            r1_y1   <= i_pts.y1;

            r2_a      <= t_prod'(r1_dx12) * t_prod'(r1_dy34);
            r2_b      <= t_prod'(r1_dy12) * t_prod'(r1_dx34);
            r2_c      <= t_prod'(r1_dx13) * t_prod'(r1_dy34);
            r2_d      <= t_prod'(r1_dy13) * t_prod'(r1_dx34);
            r2_e      <= t_prod'(r1_dy12) * t_prod'(r1_dx13);
            r2_f      <= t_prod'(r1_dx12) * t_prod'(r1_dy13);
            r2_mag_x  <= t_mag'(n2_abs_x[COORD_W-1:0]) << FRAC_BITS;
            r2_mag_y  <= t_mag'(n2_abs_y[COORD_W-1:0]) << FRAC_BITS;
            r2_neg_x  <= (r1_dx12 > 0);
            r2_neg_y  <= (r1_dy12 > 0);
            r2_base_x <= t_base'(r1_x1) <<< FRAC_BITS;
            r2_base_y <= t_base'(r1_y1) <<< FRAC_BITS;

            r3_den    <= t_sdet'(r2_a) - t_sdet'(r2_b);
            r3_tn     <= t_sdet'(r2_c) - t_sdet'(r2_d);
            r3_un     <= t_sdet'(r2_e) - t_sdet'(r2_f);
            r3_mag_x  <= r2_mag_x;
            r3_mag_y  <= r2_mag_y;
            r3_neg_x  <= r2_neg_x;
            r3_neg_y  <= r2_neg_y;
            r3_base_x <= r2_base_x;
            r3_base_y <= r2_base_y;

            // flip all three so the determinant is not negative
            r4_den    <= r3_den[DET_W-1] ? -r3_den : r3_den;
            r4_tn     <= r3_den[DET_W-1] ? -r3_tn : r3_tn;
            r4_un     <= r3_den[DET_W-1] ? -r3_un : r3_un;
            r4_mag_x  <= r3_mag_x;
            r4_mag_y  <= r3_mag_y;
            r4_neg_x  <= r3_neg_x;
            r4_neg_y  <= r3_neg_y;
            r4_base_x <= r3_base_x;
            r4_base_y <= r3_base_y;

            r5_den    <= t_det'(r4_den);
            r5_tn     <= t_det'(r4_tn);
            r5_hit    <= n5_hit;
            r5_mag_x  <= r4_mag_x;
            r5_mag_y  <= r4_mag_y;
            r5_neg_x  <= r4_neg_x;
            r5_neg_y  <= r4_neg_y;
            r5_base_x <= r4_base_x;
            r5_base_y <= r4_base_y;

            // split the wide product into two partial products
            r6_px_lo <= (MAG_W+TL_W)'(r5_mag_x) * (MAG_W+TL_W)'(r5_tn[TL_W-1:0]);
            r6_py_lo <= (MAG_W+TL_W)'(r5_mag_y) * (MAG_W+TL_W)'(r5_tn[TL_W-1:0]);
            r6_px_hi <= (MAG_W+TH_W)'(r5_mag_x) * (MAG_W+TH_W)'(r5_tn[DET_W-1:TL_W]);
            r6_py_hi <= (MAG_W+TH_W)'(r5_mag_y) * (MAG_W+TH_W)'(r5_tn[DET_W-1:TL_W]);
            r6_side.hit    <= r5_hit;
            r6_side.neg_x  <= r5_neg_x;
            r6_side.neg_y  <= r5_neg_y;
            r6_side.base_x <= r5_base_x;
            r6_side.base_y <= r5_base_y;
            r6_side.den    <= r5_den;

            r7_num_x <= t_num'(r6_px_lo) + (t_num'(r6_px_hi) << TL_W);
            r7_num_y <= t_num'(r6_py_lo) + (t_num'(r6_py_hi) << TL_W);
            r7_side  <= r6_side;
        end
    end

    assign o_vld   = r_vld[6];
    assign o_num_x = r7_num_x;
    assign o_num_y = r7_num_y;
    assign o_side  = r7_side;

endmodule

`default_nettype wire

// ===== hdl/ssi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, x and y lanes in step.
`default_nettype none

module ssi_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire ssi_pkg::t_num  i_num_x,
    input  wire ssi_pkg::t_num  i_num_y,
    input  wire ssi_pkg::t_side i_side,
    output logic                o_vld,
    output ssi_pkg::t_num       o_w_x,
    output ssi_pkg::t_num       o_w_y,
    output ssi_pkg::t_side      o_side
);
    import ssi_pkg::*;

    // Working word: remainder on top, numerator bits then quotient bits below
    logic  [Q_W-1:0] r_vld;
    t_num            r_w_x [Q_W];
    t_num            r_w_y [Q_W];
    t_side           r_side [Q_W];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        t_num             w_x_in, w_y_in;
        t_side            side_in;
        logic [DET_W:0]   t_x, t_y, d_ext;
        logic             ge_x, ge_y;
        logic [DET_W:0]   s_x, s_y;

        if (k == 0) begin : g_first
            assign w_x_in  = i_num_x;
            assign w_y_in  = i_num_y;
            assign side_in = i_side;
        end else begin : g_next
            assign w_x_in  = r_w_x[k-1];
            assign w_y_in  = r_w_y[k-1];
            assign side_in = r_side[k-1];
        end

        // Trial subtract of the determinant
        always_comb begin
            d_ext = {1'b0, side_in.den};
            t_x   = {w_x_in[N_W-1:Q_W], w_x_in[Q_W-1]};
            t_y   = {w_y_in[N_W-1:Q_W], w_y_in[Q_W-1]};
            ge_x  = (t_x >= d_ext);
            ge_y  = (t_y >= d_ext);
            s_x   = ge_x ? t_x - d_ext : t_x;
            s_y   = ge_y ? t_y - d_ext : t_y;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w_x[k]  <= {s_x[DET_W-1:0], w_x_in[Q_W-2:0], ge_x};
                r_w_y[k]  <= {s_y[DET_W-1:0], w_y_in[Q_W-2:0], ge_y};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_w_x  = r_w_x[Q_W-1];
    assign o_w_y  = r_w_y[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

`default_nettype wire

// ===== hdl/segment_segment_intersection_core.sv =====
// Top level of the segment intersection core: front pipeline, divider, result stage.
// Takes one request per cycle unless the result stalls, and returns one result per request,
// in order. Requests pass through 7 front stages (differences, cross products, determinant,
// sign flip, range test, split product, numerator sum), 24 divider stages that each settle
// one quotient bit, and the result register. The whole pipeline advances together whenever
// the result register is empty or being taken, so a stall holds every stage in place. A hit
// reports the crossing point in signed fixed point with 8 fraction bits, truncated toward
// zero; a miss, including parallel and degenerate segments, reports zero coordinates.
`default_nettype none

module segment_segment_intersection_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssi_in_if.sink    i_seg,
    ssi_out_if.source o_res
);
    import ssi_pkg::*;

    typedef logic signed [V_W-1:0] t_val;

    logic  w_en;
    t_pts  w_pts;
    logic  w_f_vld, w_d_vld;
    t_num  w_f_num_x, w_f_num_y, w_d_w_x, w_d_w_y;
    t_side w_f_side, w_d_side;
    t_val  w_vx, w_vy;

    logic                    r_out_vld;
    logic                    r_out_hit;
    logic signed [OUT_W-1:0] r_out_x, r_out_y;

    // Advance when the result register is free
    assign w_en        = !r_out_vld || o_res.ready;
    assign i_seg.ready = w_en;

    assign w_pts.x1 = i_seg.first_start_x;
    assign w_pts.y1 = i_seg.first_start_y;
    assign w_pts.x2 = i_seg.first_end_x;
    assign w_pts.y2 = i_seg.first_end_y;
    assign w_pts.x3 = i_seg.second_start_x;
    assign w_pts.y3 = i_seg.second_start_y;
    assign w_pts.x4 = i_seg.second_end_x;
    assign w_pts.y4 = i_seg.second_end_y;

    ssi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_seg.valid),
        .i_pts   (w_pts),
        .o_vld   (w_f_vld),
        .o_num_x (w_f_num_x),
        .o_num_y (w_f_num_y),
        .o_side  (w_f_side)
    );

    ssi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_num_x (w_f_num_x),
        .i_num_y (w_f_num_y),
        .i_side  (w_f_side),
        .o_vld   (w_d_vld),
        .o_w_x   (w_d_w_x),
        .o_w_y   (w_d_w_y),
        .o_side  (w_d_side)
    );

    // Apply the quotient to the start point, truncating toward zero
    function automatic t_val place(input t_base base, input logic neg, input t_num w);
        t_val s;
        logic inexact;
        inexact = (w[N_W-1:Q_W] != '0);
        if (neg) begin
            s = t_val'(base) - t_val'({1'b0, w[Q_W-1:0]});
            if (inexact && s > 0) begin
                s = s - t_val'(1);
            end
        end else begin
            s = t_val'(base) + t_val'({1'b0, w[Q_W-1:0]});
            if (inexact && s < 0) begin
                s = s + t_val'(1);
            end
        end
        return s;
    endfunction

    assign w_vx = place(w_d_side.base_x, w_d_side.neg_x, w_d_w_x);
    assign w_vy = place(w_d_side.base_y, w_d_side.neg_y, w_d_w_y);

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit <= w_d_side.hit;
            r_out_x   <= w_d_side.hit ? w_vx[OUT_W-1:0] : '0;
            r_out_y   <= w_d_side.hit ? w_vy[OUT_W-1:0] : '0;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.hit     = r_out_hit;
    assign o_res.cross_x = r_out_x;
    assign o_res.cross_y = r_out_y;

endmodule

`default_nettype wire

// ===== hdl/ssi_checker.sv =====
// Port-level checks for the segment intersection core and their binding.
`default_nettype none

module ssi_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic                              i_out_hit,
    input wire logic signed [ssi_pkg::OUT_W-1:0]  i_out_x,
    input wire logic signed [ssi_pkg::OUT_W-1:0]  i_out_y
);
    import ssi_pkg::*;

    // A miss carries zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_hit) |-> (i_out_x == '0 && i_out_y == '0))
        else $error("miss with nonzero coordinates");

    // Request side is ready exactly when the result slot can move
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("request ready does not follow result flow");

    // Reset empties the result slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_hit)
            && $stable(i_out_x) && $stable(i_out_y)))
        else $error("stalled result changed");

endmodule

bind segment_segment_intersection_core ssi_checker u_ssi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_seg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_hit   (o_res.hit),
    .i_out_x     (o_res.cross_x),
    .i_out_y     (o_res.cross_y)
);

`default_nettype wire

// ===== test/segment_segment_intersection_core_checker.sv =====
// Result checker for the segment intersection core: predicts each result and compares.
`timescale 1ns / 1ps
`default_nettype none

module segment_segment_intersection_core_checker
    import ssi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssi_in_if.sink    i_seg,
    ssi_out_if.sink   i_res,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic                    hit;
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
    } t_crossing;

    t_crossing crossing_q[$];

    // Fixed-point coordinate at parameter tn/den along p0->p1, truncated toward zero
    function automatic logic signed [OUT_W-1:0] lerp_fixed(longint p0, longint p1,
                                                           longint tn, longint den);
        longint    delta;
        longint    base;
        logic [127:0] mag;
        logic [127:0] prod;
        longint    q;
        longint    v;
        logic      inexact;
        delta   = p1 - p0;
        base    = p0 * (64'sd1 <<< FRAC_BITS);
        mag     = 128'((delta < 0 ? -delta : delta)) << FRAC_BITS;
        prod    = mag * 128'(tn);
        q       = longint'(prod / 128'(den));
        inexact = (prod % 128'(den)) != 0;
        if (delta >= 0) begin
            v = base + q;
            if (inexact && v < 0) v = v + 1;
        end else begin
            v = base - q;
            if (inexact && v > 0) v = v - 1;
        end
        return v[OUT_W-1:0];
    endfunction

    // Hit test and crossing point of one pair of segments
    function automatic t_crossing predict_crossing(longint x1, longint y1, longint x2,
                                                   longint y2, longint x3, longint y3,
                                                   longint x4, longint y4);
        longint    den;
        longint    tn;
        longint    un;
        t_crossing r;
        den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
        tn  = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
        un  = (y1 - y2) * (x1 - x3) - (x1 - x2) * (y1 - y3);
        r   = '0;
        if (den == 0) return r;
        if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
        end
        if (tn < 0 || tn > den || un < 0 || un > den) return r;
        r.hit     = 1'b1;
        r.cross_x = lerp_fixed(x1, x2, tn, den);
        r.cross_y = lerp_fixed(y1, y2, tn, den);
        return r;
    endfunction

    assign o_pending = crossing_q.size();

    // Predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin
        t_crossing want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_seg.valid && i_seg.ready)
                crossing_q.push_back(predict_crossing(
                    i_seg.first_start_x, i_seg.first_start_y,
                    i_seg.first_end_x, i_seg.first_end_y,
                    i_seg.second_start_x, i_seg.second_start_y,
                    i_seg.second_end_x, i_seg.second_end_y));
            if (i_res.valid && i_res.ready) begin
                if (crossing_q.size() == 0) begin
                    $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time,
                             i_res.hit, i_res.cross_x, i_res.cross_y);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = crossing_q.pop_front();
                    if (want.hit !== i_res.hit || want.cross_x !== i_res.cross_x ||
                        want.cross_y !== i_res.cross_y) begin
                        $display("%0t: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                                 $time, want.hit, want.cross_x, want.cross_y,
                                 i_res.hit, i_res.cross_x, i_res.cross_y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/segment_segment_intersection_core_tb.sv =====
// Stimulus and verdict for the segment intersection core regression.
`timescale 1ns / 1ps
`default_nettype none

module segment_segment_intersection_core_tb;
    import ssi_pkg::*;

    localparam int RANDOM_REQUESTS = 1530;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    ssi_in_if  seg_if ();
    ssi_out_if res_if ();

    segment_segment_intersection_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if.sink),
        .o_res   (res_if.source)
    );

    segment_segment_intersection_core_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (seg_if.sink),
        .i_res        (res_if.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 64)) - t_coord'(32);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return t_coord'($urandom);
                endcase
            end
        endcase
    endfunction

    // Idle for a random gap, then offer one request and hold it until taken
    task automatic send_segments(t_pts p);
        int idle;
        idle = gap_length();
        if (idle != 0) begin
            seg_if.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        seg_if.valid          <= 1'b1;
        seg_if.first_start_x  <= p.x1;
        seg_if.first_start_y  <= p.y1;
        seg_if.first_end_x    <= p.x2;
        seg_if.first_end_y    <= p.y2;
        seg_if.second_start_x <= p.x3;
        seg_if.second_start_y <= p.y3;
        seg_if.second_end_x   <= p.x4;
        seg_if.second_end_y   <= p.y4;
        @(posedge i_clk);
        while (!seg_if.ready) @(posedge i_clk);
    endtask

    // Segments with endpoints on opposite sides of a shared centre point, so most of them cross
    function automatic t_pts crossing_pair(int mode);
        t_pts p;
        int   cx;
        int   cy;
        int   span;
        span = (mode == 0) ? 16000 : 40;
        cx   = $urandom_range(0, 2 * span) - span;
        cy   = $urandom_range(0, 2 * span) - span;
        p.x1 = t_coord'(cx - int'($urandom_range(0, span)));
        p.y1 = t_coord'(cy - int'($urandom_range(0, span)));
        p.x2 = t_coord'(cx + int'($urandom_range(0, span)));
        p.y2 = t_coord'(cy + int'($urandom_range(0, span)));
        p.x3 = t_coord'(cx + int'($urandom_range(0, span)));
        p.y3 = t_coord'(cy - int'($urandom_range(0, span)));
        p.x4 = t_coord'(cx - int'($urandom_range(0, span)));
        p.y4 = t_coord'(cy + int'($urandom_range(0, span)));
        return p;
    endfunction

    // Consumer stalls
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if ($urandom_range(0, 2) != 0) begin
                res_if.ready <= 1'b0;
                repeat (gap_length() + 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_pts p;
        int   waited;
        i_rst_n               = 1'b0;
        seg_if.valid          = 1'b0;
        seg_if.first_start_x  = '0;
        seg_if.first_start_y  = '0;
        seg_if.first_end_x    = '0;
        seg_if.first_end_y    = '0;
        seg_if.second_start_x = '0;
        seg_if.second_start_y = '0;
        seg_if.second_end_x   = '0;
        seg_if.second_end_y   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain cross, endpoint touch, parallel, collinear, degenerate, extremes
        send_segments('{16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd10, 16'sd10, 16'sd0});
        send_segments('{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd4, 16'sd0, 16'sd4, 16'sd7});
        send_segments('{16'sd0, 16'sd0, 16'sd4, 16'sd4, 16'sd0, 16'sd1, 16'sd4, 16'sd5});
        send_segments('{16'sd0, 16'sd0, 16'sd4, 16'sd4, 16'sd1, 16'sd1, 16'sd6, 16'sd6});
        send_segments('{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd0, 16'sd0, 16'sd5, 16'sd7});
        send_segments('{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd5, 16'sd0, 16'sd6, -16'sd9});
        send_segments('{16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd1, -16'sd1, 16'sd2, 16'sd2});
        send_segments('{-16'sd5, 16'sd1, 16'sd2, -16'sd1, 16'sd0, -16'sd3, -16'sd1, 16'sd4});
        send_segments('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                        16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000});
        send_segments('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                        16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFE});
        send_segments('{16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh0001,
                        16'sh0000, 16'sh8000, 16'sh0001, 16'sh7FFF});
        send_segments('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                        16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh0000});
        send_segments('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF,
                        16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000});
        send_segments('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});

        // Random: mostly crossing pairs, the rest free and extreme coordinates
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: p = crossing_pair(0);
                4, 5: p = crossing_pair(1);
                6: p = '{rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                         rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1)};
                7: p = '{rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2),
                         rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2)};
                default: p = '{rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                               rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0)};
            endcase
            send_segments(p);
        end

        // Drop the last request, drain, then allow for anything still in the pipeline
        seg_if.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("segment_segment_intersection_core regression: pass");
        end else begin
            $display("segment_segment_intersection_core regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("segment_segment_intersection_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
